### rtl/kss_pkg.sv
// Shared types, constants and the digit pattern table for the keypad scanner.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package kss_pkg;

    // Keypad geometry
    localparam int KEY_ROWS    = 4;
    localparam int KEY_COLUMNS = 4;
    localparam int ROW_W       = (KEY_ROWS > 1) ? $clog2(KEY_ROWS) : 1;
    localparam int COL_W       = (KEY_COLUMNS > 1) ? $clog2(KEY_COLUMNS) : 1;

    // Field widths
    localparam int SENSE_W  = 4;
    localparam int DRIVE_W  = 4;
    localparam int SELECT_W = 3;
    localparam int SEG_W    = 8;
    localparam int KEY_W    = 5;
    localparam int TICK_W   = 8;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int DEB_W      = 8;
    localparam int ON_W       = 4;
    localparam int GAP_W      = 4;

    localparam logic [DEB_W-1:0] DEB_RESET = 8'd20;
    localparam logic [ON_W-1:0]  ON_RESET  = 4'd1;
    localparam logic [GAP_W-1:0] GAP_RESET = 4'd2;

    // Display position codes
    localparam logic [SELECT_W-1:0] SELECT_POS1 = 3'd7;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE  = 2'd0,
        CFG_DIGIT_ON  = 2'd1,
        CFG_DIGIT_GAP = 2'd2
    } t_cfg_index;

    typedef enum logic [2:0] {
        PH_SCAN    = 3'd0,
        PH_PRESS   = 3'd1,
        PH_RELEASE = 3'd2,
        PH_RELDEB  = 3'd3,
        PH_SHOW    = 3'd4,
        PH_GAP     = 3'd5
    } t_phase;

    typedef struct packed {
        logic [DEB_W-1:0] debounce_ticks;
        logic [ON_W-1:0]  digit_on_ticks;
        logic [GAP_W-1:0] digit_gap_ticks;
    } t_cfg;

    typedef struct packed {
        logic [DRIVE_W-1:0]  column_drive;
        logic [SELECT_W-1:0] digit_select;
        logic [SEG_W-1:0]    segments;
        logic [KEY_W-1:0]    key_code;
        logic                key_event;
    } t_result;

    // Seven segment pattern for a decimal digit, bit0 is segment a
    function automatic logic [SEG_W-1:0] seg_pattern(input logic [3:0] digit);
        logic [SEG_W-1:0] pat;
        unique case (digit)
            4'd0:    pat = 8'h3F;
            4'd1:    pat = 8'h06;
            4'd2:    pat = 8'h5B;
            4'd3:    pat = 8'h4F;
            4'd4:    pat = 8'h66;
            4'd5:    pat = 8'h6D;
            4'd6:    pat = 8'h7D;
            4'd7:    pat = 8'h07;
            4'd8:    pat = 8'h7F;
            4'd9:    pat = 8'h6F;
            default: pat = '0;
        endcase
        return pat;
    endfunction

endpackage

### rtl/kss_stream_if.sv
// Valid/ready channel interfaces for the tick input and the result output.
// Depends on kss_pkg for field widths.
`timescale 1ns / 1ps

interface kss_in_if;
    import kss_pkg::*;

    logic               valid;
    logic               ready;
    logic [SENSE_W-1:0] row_sense;

    modport source (output valid, output row_sense, input ready);
    modport sink   (input valid, input row_sense, output ready);
endinterface

interface kss_out_if;
    import kss_pkg::*;

    logic                valid;
    logic                ready;
    logic [DRIVE_W-1:0]  column_drive;
    logic [SELECT_W-1:0] digit_select;
    logic [SEG_W-1:0]    segments;
    logic [KEY_W-1:0]    key_code;
    logic                key_event;

    modport source (output valid, output column_drive, output digit_select,
                    output segments, output key_code, output key_event, input ready);
    modport sink   (input valid, input column_drive, input digit_select,
                    input segments, input key_code, input key_event, output ready);
endinterface

### rtl/keypad_scan_seven_segment_show.sv
// 4x4 matrix keypad scanner with debounce and seven segment readout.
// A tick's result is written into the result queue when the tick transfers, and the output channel is fed from there.
// Throughput: one tick per cycle; a two-entry result queue keeps input transfers going
// while the output stalls, and the input stalls only when both entries are full.
// Reset (synchronous, active low): scan phase at column 0 row 0, no key held,
// result queue empty, debounce 20, digit on 1, digit gap 2.
`timescale 1ns / 1ps

module keypad_scan_seven_segment_show (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    kss_in_if.sink                         i_in,
    kss_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [kss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kss_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import kss_pkg::*;

    t_cfg    r_cfg;
    t_result core_result;
    t_result head;
    logic    buf_ready;
    logic    in_xfer;

    // Configuration registers; writes to an unknown index are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks  <= DEB_RESET;
            r_cfg.digit_on_ticks  <= ON_RESET;
            r_cfg.digit_gap_ticks <= GAP_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE:  r_cfg.debounce_ticks  <= i_cfg_data[DEB_W-1:0];
                CFG_DIGIT_ON:  r_cfg.digit_on_ticks  <= i_cfg_data[ON_W-1:0];
                CFG_DIGIT_GAP: r_cfg.digit_gap_ticks <= i_cfg_data[GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept a tick whenever the result queue has room
    assign i_in.ready = buf_ready;
    assign in_xfer    = i_in.valid && buf_ready;

    // State machine: advance one step per transferred tick
    kss_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_row_sense (i_in.row_sense),
        .i_cfg       (r_cfg),
        .o_result    (core_result)
    );

    // Hold results until the output side takes them
    kss_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_xfer),
        .i_data      (core_result),
        .o_ready     (buf_ready),
        .o_valid     (o_out.valid),
        .i_pop_ready (o_out.ready),
        .o_data      (head)
    );

    assign o_out.column_drive = head.column_drive;
    assign o_out.digit_select = head.digit_select;
    assign o_out.segments     = head.segments;
    assign o_out.key_code     = head.key_code;
    assign o_out.key_event    = head.key_event;

endmodule

### rtl/kss_core.sv
// Scan/debounce/display state machine: one state update per accepted tick.
// Depends on kss_pkg.
`timescale 1ns / 1ps

module kss_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_accept,
    input  logic [kss_pkg::SENSE_W-1:0] i_row_sense,
    input  kss_pkg::t_cfg            i_cfg,
    output kss_pkg::t_result         o_result
);
    import kss_pkg::*;

    t_phase            r_phase, n_phase;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [TICK_W-1:0] r_tick, n_tick;
    logic [KEY_W-1:0]  r_held, n_held;
    logic              r_digit, n_digit;

    logic [KEY_ROWS-1:0] row_hit;
    logic                scan_found;
    logic [ROW_W-1:0]    scan_row;
    logic [TICK_W-1:0]   tick_inc;
    logic [DEB_W-1:0]    deb_limit;
    logic [ON_W-1:0]     on_limit;
    logic                col_last, row_last, two_digit;
    logic [KEY_W-1:0]    new_key;
    logic [3:0]          shown_digit;
    logic                key_event;
    logic [DRIVE_W-1:0]  drive;
    logic [SELECT_W-1:0] select;
    logic [SEG_W-1:0]    segs;

    // Row sense decode and the top-down search from the current row
    always_comb begin
        int b;
        row_hit    = '0;
        scan_found = 1'b0;
        scan_row   = r_row;
        for (int r = 0; r < KEY_ROWS; r++) begin
            b = KEY_ROWS - 1 - r;
            if (b < SENSE_W) begin
                row_hit[r] = ~i_row_sense[b];
            end
        end
        for (int r = KEY_ROWS - 1; r >= 0; r--) begin
            if (row_hit[r] && (r >= int'(r_row))) begin
                scan_found = 1'b1;
                scan_row   = ROW_W'(r);
            end
        end
    end

    assign tick_inc  = r_tick + 1'b1;
    assign deb_limit = (i_cfg.debounce_ticks == '0) ? DEB_W'(1) : i_cfg.debounce_ticks;
    assign on_limit  = (i_cfg.digit_on_ticks == '0) ? ON_W'(1) : i_cfg.digit_on_ticks;
    assign col_last  = (r_col == COL_W'(KEY_COLUMNS - 1));
    assign row_last  = (r_row == ROW_W'(KEY_ROWS - 1));
    assign two_digit = (r_held >= KEY_W'(10));
    assign new_key   = KEY_W'(int'(r_row) * KEY_COLUMNS + int'(r_col) + 1);

    // Next state
    always_comb begin
        n_phase   = r_phase;
        n_col     = r_col;
        n_row     = r_row;
        n_tick    = r_tick;
        n_held    = r_held;
        n_digit   = r_digit;
        key_event = 1'b0;
        unique case (r_phase)
            PH_PRESS: begin
                n_tick = tick_inc;
                if (tick_inc >= deb_limit) begin
                    n_phase = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (!row_hit[r_row]) begin
                    n_phase = PH_RELDEB;
                    n_tick  = '0;
                end
            end
            PH_RELDEB: begin
                n_tick = tick_inc;
                if (tick_inc >= deb_limit) begin
                    n_held    = new_key;
                    key_event = 1'b1;
                    if (row_last) begin
                        n_row = '0;
                        if (col_last) begin
                            n_col   = '0;
                            n_phase = PH_SHOW;
                            n_digit = 1'b0;
                            n_tick  = '0;
                        end else begin
                            n_col   = r_col + 1'b1;
                            n_phase = PH_SCAN;
                        end
                    end else begin
                        n_row   = r_row + 1'b1;
                        n_phase = PH_SCAN;
                    end
                end
            end
            PH_SHOW: begin
                n_tick = tick_inc;
                if (tick_inc >= TICK_W'(on_limit)) begin
                    n_tick = '0;
                    if (two_digit && (i_cfg.digit_gap_ticks != '0)) begin
                        n_phase = PH_GAP;
                    end else if (two_digit && !r_digit) begin
                        n_digit = 1'b1;
                        n_phase = PH_SHOW;
                    end else begin
                        n_digit = 1'b0;
                        n_phase = PH_SCAN;
                    end
                end
            end
            PH_GAP: begin
                n_tick = tick_inc;
                if (tick_inc >= TICK_W'(i_cfg.digit_gap_ticks)) begin
                    n_tick = '0;
                    if (two_digit && !r_digit) begin
                        n_digit = 1'b1;
                        n_phase = PH_SHOW;
                    end else begin
                        n_digit = 1'b0;
                        n_phase = PH_SCAN;
                    end
                end
            end
            default: begin
                // scan, and any code that means nothing
                if (scan_found) begin
                    n_row   = scan_row;
                    n_phase = PH_PRESS;
                    n_tick  = '0;
                end else begin
                    n_row = '0;
                    if (col_last) begin
                        n_col   = '0;
                        n_phase = PH_SHOW;
                        n_digit = 1'b0;
                        n_tick  = '0;
                    end else begin
                        n_col   = r_col + 1'b1;
                        n_phase = PH_SCAN;
                    end
                end
            end
        endcase
    end

    // Digit value on the display: code below ten, leading one, or the units
    always_comb begin
        if (!two_digit) begin
            shown_digit = r_held[3:0];
        end else if (!r_digit) begin
            shown_digit = 4'd1;
        end else if (r_held >= KEY_W'(30)) begin
            shown_digit = 4'(r_held - KEY_W'(30));
        end else if (r_held >= KEY_W'(20)) begin
            shown_digit = 4'(r_held - KEY_W'(20));
        end else begin
            shown_digit = 4'(r_held - KEY_W'(10));
        end
    end

    // Column, select and segment outputs from the state held before this tick
    always_comb begin
        int b;
        drive  = '1;
        select = SELECT_POS1;
        segs   = '0;
        b      = KEY_COLUMNS - 1 - int'(r_col);
        unique case (r_phase)
            PH_SHOW: begin
                select = SELECT_POS1 - SELECT_W'(r_digit);
                segs   = seg_pattern(shown_digit);
            end
            PH_GAP: begin
                select = SELECT_POS1 - SELECT_W'(r_digit);
            end
            default: begin
                if (b >= 0 && b < DRIVE_W) begin
                    drive = ~(DRIVE_W'(1) << b);
                end
            end
        endcase
    end

    assign o_result.column_drive = drive;
    assign o_result.digit_select = select;
    assign o_result.segments     = segs;
    assign o_result.key_code     = n_held;
    assign o_result.key_event    = key_event;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SCAN;
            r_col   <= '0;
            r_row   <= '0;
            r_tick  <= '0;
            r_held  <= '0;
            r_digit <= 1'b0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_tick  <= n_tick;
            r_held  <= n_held;
            r_digit <= n_digit;
        end
    end

endmodule

### rtl/kss_out_buf.sv
// Two-entry result queue between the state machine and the output channel.
// Depends on kss_pkg for the result type.
`timescale 1ns / 1ps

module kss_out_buf (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kss_pkg::t_result i_data,
    output logic             o_ready,
    output logic             o_valid,
    input  logic             i_pop_ready,
    output kss_pkg::t_result o_data
);
    import kss_pkg::*;

    t_result    r_q0, r_q1;
    logic [1:0] r_cnt;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_q0;
    assign pop     = o_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_push && !pop) begin
            r_cnt <= r_cnt + 2'd1;
        end else if (pop && !i_push) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    // Payload: shift toward the head on a pop, append behind the last entry
    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_push && r_cnt == 2'd1) begin
                r_q0 <= i_data;
            end else begin
                r_q0 <= r_q1;
            end
            if (i_push && r_cnt == 2'd2) begin
                r_q1 <= i_data;
            end
        end else if (i_push) begin
            if (r_cnt == 2'd0) begin
                r_q0 <= i_data;
            end else begin
                r_q1 <= i_data;
            end
        end
    end

endmodule

### bench/kss_readout_checker.sv
// Scoreboard for the keypad scanner: predicts one readout per transferred tick and
// compares it with the result channel. Depends on kss_pkg and kss_stream_if.
`timescale 1ns / 1ps

module kss_readout_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    kss_in_if                              i_tick,
    kss_out_if                             i_show,
    input  logic                           i_cfg_we,
    input  logic [kss_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [kss_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_key_events,
    output int                             o_lit_digits
);
    import kss_pkg::*;

    // Timing registers as the block should hold them
    logic [DEB_W-1:0] deb_ticks;
    logic [ON_W-1:0]  on_ticks;
    logic [GAP_W-1:0] gap_ticks;

    // Scanner state
    t_phase            phase;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [TICK_W-1:0] cnt;
    logic [KEY_W-1:0]  held;
    logic              disp;

    t_result readout_q[$];
    t_result want;
    t_result got;

    int fail_count   = 0;
    int checked      = 0;
    int key_events   = 0;
    int lit_digits   = 0;

    assign o_fail_count = fail_count;
    assign o_checked    = checked;
    assign o_key_events = key_events;
    assign o_lit_digits = lit_digits;

    function automatic logic [SEG_W-1:0] digit_glyph(input logic [3:0] d);
        case (d)
            4'd0:    return 8'h3F;
            4'd1:    return 8'h06;
            4'd2:    return 8'h5B;
            4'd3:    return 8'h4F;
            4'd4:    return 8'h66;
            4'd5:    return 8'h6D;
            4'd6:    return 8'h7D;
            4'd7:    return 8'h07;
            4'd8:    return 8'h7F;
            4'd9:    return 8'h6F;
            default: return '0;
        endcase
    endfunction

    function automatic logic row_low(input logic [SENSE_W-1:0] lines, input int r);
        return (r < KEY_ROWS) && (lines[KEY_ROWS-1-r] == 1'b0);
    endfunction

    // A zero count register behaves as one
    function automatic logic [TICK_W-1:0] nonzero(input logic [TICK_W-1:0] v);
        return (v == '0) ? 1 : v;
    endfunction

    task automatic step_column();
        row = '0;
        if (col == KEY_COLUMNS-1) begin
            col   = '0;
            phase = PH_SHOW;
            disp  = 1'b0;
            cnt   = '0;
        end else begin
            col   = col + 1'b1;
            phase = PH_SCAN;
        end
    endtask

    task automatic finish_digit();
        cnt = '0;
        if (held >= 10 && !disp) begin
            disp  = 1'b1;
            phase = PH_SHOW;
        end else begin
            disp  = 1'b0;
            phase = PH_SCAN;
        end
    endtask

    task automatic advance_scanner(input logic [SENSE_W-1:0] lines, output t_result res);
        int r;
        logic [3:0] d;
        res = '0;
        res.column_drive = '1;
        res.digit_select = SELECT_POS1;
        if (phase != PH_SHOW && phase != PH_GAP) begin
            res.column_drive = ~(4'b1000 >> col);
        end else begin
            res.digit_select = SELECT_POS1 - {2'b00, disp};
            if (phase == PH_SHOW) begin
                if (held < 10)  d = held[3:0];
                else if (!disp) d = 4'd1;
                else            d = 4'(held % 10);
                res.segments = digit_glyph(d);
            end
        end
        case (phase)
            PH_PRESS: begin
                cnt = cnt + 1'b1;
                if (cnt >= nonzero(deb_ticks)) phase = PH_RELEASE;
            end
            PH_RELEASE: begin
                if (!row_low(lines, row)) begin
                    phase = PH_RELDEB;
                    cnt   = '0;
                end
            end
            PH_RELDEB: begin
                cnt = cnt + 1'b1;
                if (cnt >= nonzero(deb_ticks)) begin
                    held = KEY_W'(row * KEY_COLUMNS + col + 1);
                    res.key_event = 1'b1;
                    if (row == KEY_ROWS-1) begin
                        step_column();
                    end else begin
                        row   = row + 1'b1;
                        phase = PH_SCAN;
                    end
                end
            end
            PH_SHOW: begin
                cnt = cnt + 1'b1;
                if (cnt >= nonzero({4'b0, on_ticks})) begin
                    if (held >= 10 && gap_ticks != 0) begin
                        phase = PH_GAP;
                        cnt   = '0;
                    end else begin
                        finish_digit();
                    end
                end
            end
            PH_GAP: begin
                cnt = cnt + 1'b1;
                if (cnt >= {4'b0, gap_ticks}) finish_digit();
            end
            default: begin
                r = row;
                while (r < KEY_ROWS && !row_low(lines, r)) r++;
                if (r < KEY_ROWS) begin
                    row   = ROW_W'(r);
                    phase = PH_PRESS;
                    cnt   = '0;
                end else begin
                    step_column();
                end
            end
        endcase
        res.key_code = held;
    endtask

    task automatic compare_field(input string field, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            deb_ticks = DEB_RESET;
            on_ticks  = ON_RESET;
            gap_ticks = GAP_RESET;
            phase     = PH_SCAN;
            col       = '0;
            row       = '0;
            cnt       = '0;
            held      = '0;
            disp      = 1'b0;
            readout_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_index'(i_cfg_index))
                    CFG_DEBOUNCE:  deb_ticks = i_cfg_data[DEB_W-1:0];
                    CFG_DIGIT_ON:  on_ticks  = i_cfg_data[ON_W-1:0];
                    CFG_DIGIT_GAP: gap_ticks = i_cfg_data[GAP_W-1:0];
                    default: ;
                endcase
            end
            if (i_show.valid && i_show.ready) begin
                got.column_drive = i_show.column_drive;
                got.digit_select = i_show.digit_select;
                got.segments     = i_show.segments;
                got.key_code     = i_show.key_code;
                got.key_event    = i_show.key_event;
                if (readout_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: readout with nothing expected, actual %h", $time, got);
                end else begin
                    want = readout_q.pop_front();
                    checked++;
                    compare_field("column_drive", want.column_drive, got.column_drive);
                    compare_field("digit_select", want.digit_select, got.digit_select);
                    compare_field("segments", want.segments, got.segments);
                    compare_field("key_code", want.key_code, got.key_code);
                    compare_field("key_event", want.key_event, got.key_event);
                    if (want.key_event) key_events++;
                    if (want.segments != '0) lit_digits++;
                end
            end
            if (i_tick.valid && i_tick.ready) begin
                advance_scanner(i_tick.row_sense, want);
                readout_q.push_back(want);
            end
        end
        o_pending <= readout_q.size();
    end

endmodule

### bench/keypad_scan_seven_segment_show_test.sv
// Testbench top for the keypad scanner: drives row ticks and timing registers,
// stalls the readout side, and reports the verdict. Depends on kss_pkg,
// kss_stream_if and kss_readout_checker.
`timescale 1ns / 1ps

module keypad_scan_seven_segment_show_test;
    import kss_pkg::*;

    localparam int NUM_PLANS       = 6;
    localparam int HOLD_OFF_CYCLES = 64;
    localparam int LIMIT_CYCLES    = 400_000;

    // Timing settings for the random part: extremes first, the slow debounce last
    int plan_deb   [NUM_PLANS] = '{0, 1, 3, 2, 7, 255};
    int plan_on    [NUM_PLANS] = '{0, 15, 1, 4, 15, 15};
    int plan_gap   [NUM_PLANS] = '{0, 15, 0, 7, 0, 15};
    int plan_items [NUM_PLANS] = '{200, 250, 250, 200, 150, 600};

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int  fail_count;
    int  pending;
    int  checked;
    int  key_events;
    int  lit_digits;
    int  ticks_sent  = 0;
    int  cycle_count = 0;
    bit  idle_on     = 1'b1;
    bit  hold_off    = 1'b0;

    kss_in_if  tick_if();
    kss_out_if show_if();

    keypad_scan_seven_segment_show u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (tick_if),
        .o_out       (show_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    kss_readout_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (tick_if),
        .i_show       (show_if),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_key_events (key_events),
        .o_lit_digits (lit_digits)
    );

    // 20 ns period
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: end the run if the handshakes ever lock up
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d readouts outstanding", cycle_count, pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Offer one tick; draw a gap first, hold valid until the transfer, return at a falling edge
    task automatic send_lines(input logic [SENSE_W-1:0] lines);
        int gap;
        gap = (idle_on && !hold_off) ? $urandom_range(0, 17) : 0;
        if (gap != 0) begin
            tick_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_if.valid     <= 1'b1;
        tick_if.row_sense <= lines;
        do @(posedge i_clk); while (!tick_if.ready);
        ticks_sent++;
        @(negedge i_clk);
    endtask

    // Hold the row lines low for a while, then release them
    task automatic press_key(input logic [SENSE_W-1:0] lines, input int hold, input int rel);
        repeat (hold) send_lines(lines);
        repeat (rel) send_lines(4'hF);
    endtask

    // Drop valid and wait until every readout has come back, plus the output latency
    task automatic settle();
        tick_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    // Write all three timing registers in turn
    task automatic program_timing(input logic [DEB_W-1:0] deb, input logic [ON_W-1:0] on,
                                  input logic [GAP_W-1:0] gap);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEBOUNCE;
        i_cfg_data  <= deb;
        @(negedge i_clk);
        i_cfg_index <= CFG_DIGIT_ON;
        i_cfg_data  <= CFG_DATA_W'(on);
        @(negedge i_clk);
        i_cfg_index <= CFG_DIGIT_GAP;
        i_cfg_data  <= CFG_DATA_W'(gap);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // Mostly clean press/release episodes of random length and row, plus some
    // noise on the rows and some contact bounce
    task automatic drive_keypad(input int items, input int deb);
        int sent;
        int roll;
        int hold;
        int rel;
        int n;
        logic [SENSE_W-1:0] lines;
        sent = 0;
        while (sent < items) begin
            roll  = $urandom_range(0, 99);
            lines = 4'hF;
            lines[$urandom_range(0, 3)] = 1'b0;
            if ($urandom_range(0, 4) == 0) lines = lines & 4'($urandom_range(0, 15));
            if (roll < 75) begin
                hold = $urandom_range(1, 2 * deb + 4);
                rel  = $urandom_range(deb, 2 * deb + 8);
                press_key(lines, hold, rel);
                sent += hold + rel;
            end else if (roll < 90) begin
                n = $urandom_range(1, 8);
                repeat (n) send_lines(4'($urandom_range(0, 15)));
                sent += n;
            end else begin
                n = $urandom_range(1, 4);
                repeat (n) press_key(lines, 1, 1);
                sent += 2 * n;
            end
        end
    endtask

    // Readout side: random stalls per transfer, and one long hold-off on request
    initial begin
        int stall;
        show_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_off) begin
                show_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
                hold_off = 1'b0;
            end
            stall = idle_on ? $urandom_range(0, 17) : 0;
            if (stall != 0) begin
                show_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            show_if.ready <= 1'b1;
            do @(posedge i_clk); while (!show_if.valid);
            @(negedge i_clk);
        end
    end

    // Stimulus and verdict
    initial begin
        int p;
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_DEBOUNCE;
        i_cfg_data        <= '0;
        tick_if.valid     <= 1'b0;
        tick_if.row_sense <= 4'hF;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset timing, no keys: one full scan, then the readout shows zero
        repeat (5) send_lines(4'hF);
        settle();

        // Shortest debounce: top row, all rows at once (the top row at or below the scan row wins), bottom row,
        // then idle long enough to show a two digit key with a gap
        program_timing(8'd1, 4'd1, 4'd1);
        press_key(4'h7, 2, 2);
        press_key(4'h0, 2, 2);
        press_key(4'hE, 2, 2);
        repeat (6) send_lines(4'hF);

        for (p = 0; p < NUM_PLANS; p++) begin
            settle();
            program_timing(DEB_W'(plan_deb[p]), ON_W'(plan_on[p]), GAP_W'(plan_gap[p]));
            idle_on = (p % 2 == 0);
            // Stall the readout long enough to fill the block and back up the ticks
            if (p == 1) hold_off = 1'b1;
            drive_keypad(plan_items[p], (plan_deb[p] == 0) ? 1 : plan_deb[p]);
        end
        settle();

        $display("Sent %0d row ticks over %0d timing settings; checked %0d readouts,",
                 ticks_sent, NUM_PLANS + 2, checked);
        $display("including %0d qualified key releases and %0d lit digits.",
                 key_events, lit_digits);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
